// ===== hdl/midi_byte_stream_parser_macros.svh =====
// Assertion macros used by the RTL.
`ifndef MIDI_BYTE_STREAM_PARSER_MACROS_SVH
`define MIDI_BYTE_STREAM_PARSER_MACROS_SVH

`ifndef SYNTHESIS

`define MBSP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbsp assertion failed");

`define MBSP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbsp assertion failed");

`else

`define MBSP_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define MBSP_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/mbsp_pkg.sv =====
package mbsp_pkg;

    localparam logic [7:0] STATUS_NONE   = 8'h00;
    localparam logic [7:0] STATUS_SYSEX  = 8'h01;

    localparam logic [7:0] NOTE_OFF_MIN  = 8'h80;
    localparam logic [7:0] PROG_CHG_MIN  = 8'hC0;
    localparam logic [7:0] PITCH_MIN     = 8'hE0;
    localparam logic [7:0] SYSEX_START   = 8'hF0;
    localparam logic [7:0] MTC_QFRAME    = 8'hF1;
    localparam logic [7:0] SONG_POS      = 8'hF2;
    localparam logic [7:0] SONG_SELECT   = 8'hF3;
    localparam logic [7:0] TUNE_REQUEST  = 8'hF6;
    localparam logic [7:0] SYSEX_END     = 8'hF7;
    localparam logic [7:0] REALTIME_MIN  = 8'hF8;

    typedef struct packed {
        logic [1:0] byte_count;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       message_complete;
        logic       realtime_valid;
        logic [7:0] realtime_byte;
    } mbsp_result_t;

endpackage

// ===== hdl/mbsp_if.sv =====
interface mbsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

interface mbsp_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] byte_count;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       message_complete;
    logic       realtime_valid;
    logic [7:0] realtime_byte;

    modport source (
        output valid, output byte_count, output first_byte, output second_byte,
        output message_complete, output realtime_valid, output realtime_byte,
        input ready
    );
    modport sink (
        input valid, input byte_count, input first_byte, input second_byte,
        input message_complete, input realtime_valid, input realtime_byte,
        output ready
    );
endinterface

// ===== hdl/midi_byte_stream_parser.sv =====
// An accepted byte is held in the input register, then decoded into the result register.
// Throughput: one byte per cycle unless output stalls; running status decode is combinational.
// One further byte is taken while a finished result word waits on the output.
// Reset (rst_n low, asynchronous): running status none, no third byte pending, both stages empty.
`include "midi_byte_stream_parser_macros.svh"

module midi_byte_stream_parser
    import mbsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mbsp_byte_if.sink   midi_in,
    mbsp_result_if.source result
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic [7:0]   rs_reg;
    logic [7:0]   rs_next;
    logic         exp_reg;
    logic         exp_next;
    logic         out_valid_reg;
    mbsp_result_t out_reg;
    mbsp_result_t out_next;
    logic         advance;
    logic         sysex;

    assign advance       = !out_valid_reg || result.ready;
    assign midi_in.ready = !in_valid_reg || advance;

    always_comb
    begin
        out_next = '0;
        rs_next  = rs_reg;
        exp_next = exp_reg;
        sysex    = (rs_reg == STATUS_SYSEX);
        if (in_byte_reg[7])
        begin
            if (in_byte_reg >= REALTIME_MIN)
            begin
                out_next.realtime_valid = 1'b1;
                out_next.realtime_byte  = in_byte_reg;
            end
            else
            begin
                rs_next  = (in_byte_reg <= SONG_SELECT) ? in_byte_reg : STATUS_NONE;
                exp_next = 1'b0;
                if (sysex)
                begin
                    out_next.byte_count       = 2'd1;
                    out_next.first_byte       = SYSEX_END;
                    out_next.message_complete = 1'b1;
                end
                if (in_byte_reg == TUNE_REQUEST)
                begin
                    out_next.message_complete = 1'b1;
                    if (sysex)
                    begin
                        out_next.byte_count  = 2'd2;
                        out_next.second_byte = TUNE_REQUEST;
                    end
                    else
                    begin
                        out_next.byte_count = 2'd1;
                        out_next.first_byte = TUNE_REQUEST;
                    end
                end
            end
        end
        else if (exp_reg)
        begin
            exp_next                  = 1'b0;
            out_next.byte_count       = 2'd1;
            out_next.first_byte       = in_byte_reg;
            out_next.message_complete = 1'b1;
        end
        else if (sysex)
        begin
            out_next.byte_count = 2'd1;
            out_next.first_byte = in_byte_reg;
        end
        else if (rs_reg >= NOTE_OFF_MIN && rs_reg <= SONG_SELECT)
        begin
            // status re-emitted ahead of the first data byte
            out_next.byte_count  = 2'd2;
            out_next.first_byte  = rs_reg;
            out_next.second_byte = in_byte_reg;
            if (rs_reg < PROG_CHG_MIN)
            begin
                exp_next = 1'b1;
            end
            else if (rs_reg < PITCH_MIN)
            begin
                out_next.message_complete = 1'b1;
            end
            else if (rs_reg < SYSEX_START)
            begin
                exp_next = 1'b1;
            end
            else if (rs_reg == SYSEX_START)
            begin
                rs_next = STATUS_SYSEX;
            end
            else if (rs_reg == SONG_POS)
            begin
                exp_next = 1'b1;
                rs_next  = STATUS_NONE;
            end
            else
            begin
                out_next.message_complete = 1'b1;
                rs_next                   = STATUS_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rs_reg        <= STATUS_NONE;
            exp_reg       <= 1'b0;
        end
        else
        begin
            if (midi_in.ready)
            begin
                in_valid_reg <= midi_in.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance && in_valid_reg)
            begin
                rs_reg  <= rs_next;
                exp_reg <= exp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (midi_in.ready && midi_in.valid)
        begin
            in_byte_reg <= midi_in.byte_in;
        end
        if (advance && in_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.byte_count       = out_reg.byte_count;
    assign result.first_byte       = out_reg.first_byte;
    assign result.second_byte      = out_reg.second_byte;
    assign result.message_complete = out_reg.message_complete;
    assign result.realtime_valid   = out_reg.realtime_valid;
    assign result.realtime_byte    = out_reg.realtime_byte;

    `MBSP_ASSERT_IMP(a_rs_legal, clk, rst_n, 1'b1,
        rs_reg == STATUS_NONE || rs_reg == STATUS_SYSEX || rs_reg[7])
    `MBSP_ASSERT_IMP(a_third_ctx, clk, rst_n, exp_reg,
        rs_reg == STATUS_NONE || (rs_reg >= NOTE_OFF_MIN && rs_reg < SYSEX_START))
    `MBSP_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid_reg && !result.ready,
        $stable(rs_reg) && $stable(exp_reg))
    `MBSP_ASSERT_IMP(a_rt_alone, clk, rst_n, out_valid_reg && out_reg.realtime_valid,
        out_reg.byte_count == 2'd0 && !out_reg.message_complete)

endmodule

// ===== tb/midi_byte_stream_parser_test.sv =====
`timescale 1ns / 1ps

module midi_byte_stream_parser_test;
    import mbsp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_WORDS = 750;
    localparam int HOLD_CYCLES = 80;
    localparam logic [7:0] UNDEFINED_F4 = 8'hF4;
    localparam logic [7:0] UNDEFINED_F5 = 8'hF5;
    localparam logic [7:0] REALTIME_MAX = 8'hFF;

    class midi_parse_checker;
        logic [7:0] held_status;
        bit third_due;
        mbsp_result_t pending_words[$];
        int busy_words;
        int noted_words;
        int checked_words;
        int failures;

        function new();
            held_status = STATUS_NONE;
            third_due = 1'b0;
            busy_words = 0;
            noted_words = 0;
            checked_words = 0;
            failures = 0;
        endfunction

        function void append(inout mbsp_result_t w, input logic [7:0] v);
            if (w.byte_count == 2'd0)
            begin
                w.first_byte = v;
                w.byte_count = 2'd1;
            end
            else if (w.byte_count == 2'd1)
            begin
                w.second_byte = v;
                w.byte_count = 2'd2;
            end
        endfunction

        function mbsp_result_t parse_byte(logic [7:0] b);
            mbsp_result_t w;
            logic [7:0] rs;
            w = '0;
            rs = held_status;
            if (b[7])
            begin
                if (b >= REALTIME_MIN)
                begin
                    w.realtime_valid = 1'b1;
                    w.realtime_byte = b;
                end
                else
                begin
                    if (rs == STATUS_SYSEX)
                    begin
                        append(w, SYSEX_END);
                        w.message_complete = 1'b1;
                    end
                    held_status = (b <= SONG_SELECT) ? b : STATUS_NONE;
                    third_due = 1'b0;
                    if (b == TUNE_REQUEST)
                    begin
                        append(w, b);
                        w.message_complete = 1'b1;
                    end
                end
            end
            else if (third_due)
            begin
                third_due = 1'b0;
                append(w, b);
                w.message_complete = 1'b1;
            end
            else if (rs == STATUS_SYSEX)
            begin
                append(w, b);
            end
            else if ((rs >= NOTE_OFF_MIN && rs < PROG_CHG_MIN)
                     || (rs >= PITCH_MIN && rs < SYSEX_START))
            begin
                third_due = 1'b1;
                append(w, rs);
                append(w, b);
            end
            else if (rs >= PROG_CHG_MIN && rs < PITCH_MIN)
            begin
                append(w, rs);
                append(w, b);
                w.message_complete = 1'b1;
            end
            else if (rs == SONG_POS)
            begin
                third_due = 1'b1;
                append(w, rs);
                append(w, b);
                held_status = STATUS_NONE;
            end
            else if (rs == MTC_QFRAME || rs == SONG_SELECT)
            begin
                append(w, rs);
                append(w, b);
                held_status = STATUS_NONE;
                w.message_complete = 1'b1;
            end
            else if (rs == SYSEX_START)
            begin
                append(w, rs);
                append(w, b);
                held_status = STATUS_SYSEX;
            end
            return w;
        endfunction

        function void note_byte(logic [7:0] b);
            mbsp_result_t w;
            w = parse_byte(b);
            if (w != '0)
                busy_words++;
            noted_words++;
            pending_words.push_back(w);
        endfunction

        task report(string msg);
            failures++;
            if (failures <= 100)
                $display("%0t mismatch: %s", $time, msg);
        endtask

        task check_word(mbsp_result_t got);
            mbsp_result_t exp;
            if (pending_words.size() == 0)
            begin
                report($sformatf("unexpected word %h", got));
                return;
            end
            exp = pending_words.pop_front();
            checked_words++;
            if (got.byte_count !== exp.byte_count)
                report($sformatf("word %0d byte_count %h, want %h",
                                 checked_words, got.byte_count, exp.byte_count));
            if (got.first_byte !== exp.first_byte)
                report($sformatf("word %0d first_byte %h, want %h",
                                 checked_words, got.first_byte, exp.first_byte));
            if (got.second_byte !== exp.second_byte)
                report($sformatf("word %0d second_byte %h, want %h",
                                 checked_words, got.second_byte, exp.second_byte));
            if (got.message_complete !== exp.message_complete)
                report($sformatf("word %0d message_complete %b, want %b",
                                 checked_words, got.message_complete, exp.message_complete));
            if (got.realtime_valid !== exp.realtime_valid)
                report($sformatf("word %0d realtime_valid %b, want %b",
                                 checked_words, got.realtime_valid, exp.realtime_valid));
            if (got.realtime_byte !== exp.realtime_byte)
                report($sformatf("word %0d realtime_byte %h, want %h",
                                 checked_words, got.realtime_byte, exp.realtime_byte));
        endtask

        function int pending();
            return pending_words.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    midi_parse_checker sb = new();

    mbsp_byte_if midi_in();
    mbsp_result_if result();

    midi_byte_stream_parser u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .midi_in(midi_in),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        midi_in.valid = 1'b0;
        midi_in.byte_in = 8'h00;
        result.ready = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // no idling while the busy count is in the steady window
    function bit idle_now();
        if (sb.busy_words >= 250 && sb.busy_words < 400)
            return 1'b0;
        return $urandom_range(0, 99) < 14;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while (idle_now())
        begin
            midi_in.valid <= 1'b0;
            @(negedge clk);
        end
        midi_in.valid <= 1'b1;
        midi_in.byte_in <= b;
        do
            @(posedge clk);
        while (!midi_in.ready);
        sb.note_byte(b);
        @(negedge clk);
    endtask

    task automatic send_message();
        logic [7:0] msg[$];
        logic [7:0] st;
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            st = 8'h80 | 8'($urandom_range(0, 6) << 4) | 8'($urandom_range(0, 15));
            len = (st >= PROG_CHG_MIN && st < PITCH_MIN) ? 1 : 2;
            // running status: status sometimes left out
            if ($urandom_range(0, 3) != 0)
                msg.push_back(st);
            repeat ($urandom_range(1, 3))
                repeat (len)
                    msg.push_back(8'($urandom_range(0, 127)));
        end
        else if (pick < 67)
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    msg.push_back(MTC_QFRAME);
                    msg.push_back(8'($urandom_range(0, 127)));
                end
                1:
                begin
                    msg.push_back(SONG_POS);
                    msg.push_back(8'($urandom_range(0, 127)));
                    msg.push_back(8'($urandom_range(0, 127)));
                end
                2:
                begin
                    msg.push_back(SONG_SELECT);
                    msg.push_back(8'($urandom_range(0, 127)));
                end
                3:
                    msg.push_back(TUNE_REQUEST);
                default:
                    msg.push_back(SYSEX_END);
            endcase
        end
        else if (pick < 80)
        begin
            msg.push_back(SYSEX_START);
            repeat ($urandom_range(0, 10))
                msg.push_back(8'($urandom_range(0, 127)));
            if ($urandom_range(0, 99) < 70)
                msg.push_back(SYSEX_END);
            else
                msg.push_back(8'($urandom_range(NOTE_OFF_MIN, SYSEX_END)));
        end
        else if (pick < 87)
        begin
            msg.push_back($urandom_range(0, 1) ? UNDEFINED_F4 : UNDEFINED_F5);
            repeat ($urandom_range(0, 3))
                msg.push_back(8'($urandom_range(0, 127)));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                msg.push_back(8'($urandom_range(0, 255)));
        end
        foreach (msg[i])
        begin
            if ($urandom_range(0, 99) < 6)
                send_byte(8'($urandom_range(REALTIME_MIN, REALTIME_MAX)));
            send_byte(msg[i]);
        end
    endtask

    initial
    begin
        logic [7:0] intro[] = '{
            REALTIME_MIN, 8'h00, NOTE_OFF_MIN, 8'h3C, 8'h7F, 8'h40, 8'h00,
            8'hC5, 8'h10, 8'hE3, 8'h00, 8'h7F,
            SONG_POS, 8'h01, 8'h02, SONG_SELECT, 8'h7F, MTC_QFRAME, 8'h33,
            SYSEX_START, 8'h01, TUNE_REQUEST, SYSEX_START, 8'h7F, SYSEX_END,
            REALTIME_MAX
        };
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (intro[i])
            send_byte(intro[i]);
        while (sb.noted_words < RANDOM_WORDS)
            send_message();
        midi_in.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        mbsp_result_t got;
        bit held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            // one long back-pressure stretch so the input side stalls
            if (!held && sb.checked_words >= 450)
            begin
                held = 1'b1;
                result.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            result.ready <= !idle_now();
            @(posedge clk);
            if (result.valid && result.ready)
            begin
                got.byte_count = result.byte_count;
                got.first_byte = result.first_byte;
                got.second_byte = result.second_byte;
                got.message_complete = result.message_complete;
                got.realtime_valid = result.realtime_valid;
                got.realtime_byte = result.realtime_byte;
                sb.check_word(got);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((midi_in.valid && midi_in.ready) || (result.valid && result.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mbsp_pkg.sv
hdl/mbsp_if.sv
hdl/midi_byte_stream_parser.sv
tb/midi_byte_stream_parser_test.sv
